// ----- hw/rtl/lrp_pkg.sv -----
// lrp_pkg: shared types and codes for the lr table parse driver
// transaction structs, command/entry/result codes and sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lrp_pkg;

  localparam int FIELD_W = 4;
  localparam int ENTRY_W = 6;
  localparam int RULE_W  = 8;

  localparam logic [1:0] CMD_WR_ENTRY = 2'd0;
  localparam logic [1:0] CMD_WR_RULE  = 2'd1;
  localparam logic [1:0] CMD_PARSE    = 2'd2;
  localparam logic [1:0] CMD_RESTART  = 2'd3;

  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_SHIFT  = 2'd1;
  localparam logic [1:0] KIND_REDUCE = 2'd2;
  localparam logic [1:0] KIND_ACCEPT = 2'd3;

  localparam logic [1:0] RES_SHIFT  = 2'd0;
  localparam logic [1:0] RES_REDUCE = 2'd1;
  localparam logic [1:0] RES_ACCEPT = 2'd2;
  localparam logic [1:0] RES_ERROR  = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FIELD_W-1:0] state_index;
    logic [FIELD_W-1:0] symbol;
    logic [1:0]         action_kind;
    logic [FIELD_W-1:0] action_target;
    logic [FIELD_W-1:0] production_index;
    logic [FIELD_W-1:0] rule_left;
    logic [FIELD_W-1:0] rule_length;
  } item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [FIELD_W-1:0] rule_used;
    logic [FIELD_W-1:0] pushed_state;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_LOOK,
    S_DEC,
    S_RULE,
    S_GSTK,
    S_GDEC
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lrp_action_mem.sv -----
// lrp_action_mem: combined action/goto table memory with registered read
// runs a clearing pass after reset that writes every entry to empty
// depends on lrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrp_action_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [lrp_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [lrp_pkg::ENTRY_W-1:0] rd_data,
  output logic                            clearing
);
  import lrp_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [AW-1:0]      cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      cnt      <= '0;
    end else if (clearing) begin
      cnt <= cnt + AW'(1);
      if (cnt == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lrp_stack_mem.sv -----
// lrp_stack_mem: parser state stack memory, one write and one registered read
// the bottom entry always reads as state zero
// depends on lrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrp_stack_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [lrp_pkg::FIELD_W-1:0] wr_data,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [lrp_pkg::FIELD_W-1:0] rd_data
);
  import lrp_pkg::*;

  logic [FIELD_W-1:0] mem [DEPTH];
  logic [FIELD_W-1:0] q;
  logic               rd_zero;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q       <= mem[rd_addr];
    rd_zero <= (rd_addr == '0);
  end

  assign rd_data = rd_zero ? '0 : q;

endmodule

`default_nettype wire

// ----- hw/rtl/lrp_seq.sv -----
// lrp_seq: parse sequencer with shared table address unit, stack pointer
// logic and production table; drives the action and stack memories
// depends on lrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrp_seq #(
  parameter int NUM_STATES      = 16,
  parameter int NUM_SYMBOLS     = 16,
  parameter int NUM_RULES       = 16,
  parameter int STACK_DEPTH     = 32,
  parameter int MAX_RULE_LENGTH = 8,
  parameter int MAX_REDUCES     = 15,
  parameter int TA_W            = 8,
  parameter int SA_W            = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire lrp_pkg::item_t              item,
  output logic                             busy,
  output lrp_pkg::result_t                 result,
  output logic                             result_valid,
  input  wire logic                        clearing,
  output logic                             tbl_wr_en,
  output logic      [TA_W-1:0]             tbl_addr,
  output logic      [lrp_pkg::ENTRY_W-1:0] tbl_wr_data,
  input  wire logic [lrp_pkg::ENTRY_W-1:0] tbl_rd_data,
  output logic                             stk_wr_en,
  output logic      [SA_W-1:0]             stk_wr_addr,
  output logic      [lrp_pkg::FIELD_W-1:0] stk_wr_data,
  output logic      [SA_W-1:0]             stk_rd_addr,
  input  wire logic [lrp_pkg::FIELD_W-1:0] stk_rd_data
);
  import lrp_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int RA_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int RC_W = $clog2(MAX_REDUCES + 1);

  state_t             state, state_next;
  logic [SP_W-1:0]    sp, sp_next;
  logic               halted, halted_next;
  logic [RC_W-1:0]    reduces, reduces_next;
  logic [FIELD_W-1:0] tok, tok_next;
  logic [FIELD_W-1:0] rule_no, rule_no_next;
  logic [FIELD_W-1:0] left, left_next;
  logic [SP_W-1:0]    remain, remain_next;
  result_t            result_next;
  logic               result_valid_next;
  logic               rng;

  logic [RULE_W-1:0]  rule_mem [NUM_RULES];
  logic [RULE_W-1:0]  rule_q;
  logic [RA_W-1:0]    rule_rd_addr;
  logic               rule_wr_en;
  logic [FIELD_W-1:0] rule_len_clamped;

  logic               accept;
  logic [FIELD_W-1:0] addr_st, addr_sym;
  logic               hit;
  logic [ENTRY_W-1:0] ent;
  logic [1:0]         ent_kind;
  logic [FIELD_W-1:0] ent_tgt;
  logic [FIELD_W-1:0] rq_len, rq_left;
  logic [SP_W-1:0]    remain_c;
  logic               err;

  assign busy   = clearing || (state != S_IDLE);
  assign accept = start && !busy;

  // shared table address unit
  always_comb begin
    case (state)
      S_LOOK: begin
        addr_st  = stk_rd_data;
        addr_sym = tok;
      end
      S_GSTK: begin
        addr_st  = stk_rd_data;
        addr_sym = left;
      end
      default: begin
        addr_st  = item.state_index;
        addr_sym = item.symbol;
      end
    endcase
  end

  assign tbl_addr    = TA_W'(32'(addr_st) * NUM_SYMBOLS + 32'(addr_sym));
  assign hit         = (32'(addr_st) < NUM_STATES) && (32'(addr_sym) < NUM_SYMBOLS);
  assign tbl_wr_en   = accept && (item.cmd == CMD_WR_ENTRY) && hit;
  assign tbl_wr_data = {item.action_kind, item.action_target};

  assign ent      = rng ? tbl_rd_data : '0;
  assign ent_kind = ent[ENTRY_W-1:FIELD_W];
  assign ent_tgt  = ent[FIELD_W-1:0];

  // production table
  assign rule_wr_en       = accept && (item.cmd == CMD_WR_RULE)
                            && (32'(item.production_index) < NUM_RULES);
  assign rule_len_clamped = (32'(item.rule_length) > MAX_RULE_LENGTH)
                            ? FIELD_W'(MAX_RULE_LENGTH) : item.rule_length;
  assign rule_rd_addr     = RA_W'(ent_tgt);
  assign rq_len           = rule_q[FIELD_W-1:0];
  assign rq_left          = rule_q[RULE_W-1:FIELD_W];
  assign remain_c         = sp - SP_W'(rq_len);

  always_ff @(posedge clk) begin
    if (rule_wr_en) begin
      rule_mem[RA_W'(item.production_index)] <= {item.rule_left, rule_len_clamped};
    end
    rule_q <= rule_mem[rule_rd_addr];
  end

  always_comb begin
    case (state)
      S_TOP:   stk_rd_addr = SA_W'(sp - SP_W'(1));
      S_RULE:  stk_rd_addr = SA_W'(remain_c - SP_W'(1));
      default: stk_rd_addr = '0;
    endcase
  end

  always_comb begin
    state_next        = state;
    sp_next           = sp;
    halted_next       = halted;
    reduces_next      = reduces;
    tok_next          = tok;
    rule_no_next      = rule_no;
    left_next         = left;
    remain_next       = remain;
    result_next       = result;
    result_valid_next = 1'b0;
    stk_wr_en         = 1'b0;
    stk_wr_addr       = '0;
    stk_wr_data       = '0;
    err               = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.cmd)
            CMD_RESTART: begin
              sp_next     = SP_W'(1);
              halted_next = 1'b0;
            end
            CMD_PARSE: begin
              if (halted) begin
                err = 1'b1;
              end else begin
                tok_next     = item.symbol;
                reduces_next = '0;
                state_next   = S_TOP;
              end
            end
            default: ;
          endcase
        end
      end
      S_TOP:  state_next = S_LOOK;
      S_LOOK: state_next = S_DEC;
      S_DEC: begin
        case (ent_kind)
          KIND_SHIFT: begin
            if (32'(sp) >= STACK_DEPTH) begin
              err = 1'b1;
            end else begin
              stk_wr_en         = 1'b1;
              stk_wr_addr       = SA_W'(sp);
              stk_wr_data       = ent_tgt;
              sp_next           = sp + SP_W'(1);
              result_next       = '{RES_SHIFT, '0, ent_tgt, 1'b1};
              result_valid_next = 1'b1;
              state_next        = S_IDLE;
            end
          end
          KIND_ACCEPT: begin
            halted_next       = 1'b1;
            result_next       = '{RES_ACCEPT, '0, '0, 1'b1};
            result_valid_next = 1'b1;
            state_next        = S_IDLE;
          end
          KIND_REDUCE: begin
            if ((32'(reduces) >= MAX_REDUCES) || (32'(ent_tgt) >= NUM_RULES)) begin
              err = 1'b1;
            end else begin
              rule_no_next = ent_tgt;
              state_next   = S_RULE;
            end
          end
          default: err = 1'b1;
        endcase
      end
      S_RULE: begin
        if ((32'(rq_len) >= 32'(sp)) || (32'(remain_c) >= STACK_DEPTH)) begin
          err = 1'b1;
        end else begin
          remain_next = remain_c;
          left_next   = rq_left;
          state_next  = S_GSTK;
        end
      end
      S_GSTK: state_next = S_GDEC;
      S_GDEC: begin
        if (ent_kind != KIND_SHIFT) begin
          err = 1'b1;
        end else begin
          stk_wr_en         = 1'b1;
          stk_wr_addr       = SA_W'(remain);
          stk_wr_data       = ent_tgt;
          sp_next           = remain + SP_W'(1);
          reduces_next      = reduces + RC_W'(1);
          result_next       = '{RES_REDUCE, rule_no, ent_tgt, 1'b0};
          result_valid_next = 1'b1;
          state_next        = S_TOP;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (err) begin
      halted_next       = 1'b1;
      result_next       = '{RES_ERROR, '0, '0, 1'b1};
      result_valid_next = 1'b1;
      state_next        = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sp           <= SP_W'(1);
      halted       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      sp           <= sp_next;
      halted       <= halted_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    reduces <= reduces_next;
    tok     <= tok_next;
    rule_no <= rule_no_next;
    left    <= left_next;
    remain  <= remain_next;
    result  <= result_next;
    rng     <= hit;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lr_table_parse_driver.sv -----
// lr_table_parse_driver: table-driven lr shift-reduce parser, top level
// table writes, production writes and restart are done from idle, busy stays low
// parse token: reads the stack top and the table, decodes, then gives the result; busy holds
// until the last result, and each reduction adds stack, table, production and goto reads
// a token on a halted run gives its error result in the next cycle
// after reset busy holds while the table is cleared
`timescale 1ns / 1ps
`default_nettype none

module lr_table_parse_driver #(
  parameter int NUM_STATES      = 16,
  parameter int NUM_SYMBOLS     = 16,
  parameter int NUM_RULES       = 16,
  parameter int STACK_DEPTH     = 32,
  parameter int MAX_RULE_LENGTH = 8,
  parameter int MAX_REDUCES     = 15
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire lrp_pkg::item_t   item,
  output logic                  busy,
  output lrp_pkg::result_t      result,
  output logic                  result_valid
);
  import lrp_pkg::*;

  localparam int TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int TA_W      = $clog2(TBL_DEPTH);
  localparam int SA_W      = $clog2(STACK_DEPTH);

  logic               clearing;
  logic               tbl_wr_en;
  logic [TA_W-1:0]    tbl_addr;
  logic [ENTRY_W-1:0] tbl_wr_data;
  logic [ENTRY_W-1:0] tbl_rd_data;
  logic               stk_wr_en;
  logic [SA_W-1:0]    stk_wr_addr;
  logic [FIELD_W-1:0] stk_wr_data;
  logic [SA_W-1:0]    stk_rd_addr;
  logic [FIELD_W-1:0] stk_rd_data;

  lrp_seq #(
    .NUM_STATES      (NUM_STATES),
    .NUM_SYMBOLS     (NUM_SYMBOLS),
    .NUM_RULES       (NUM_RULES),
    .STACK_DEPTH     (STACK_DEPTH),
    .MAX_RULE_LENGTH (MAX_RULE_LENGTH),
    .MAX_REDUCES     (MAX_REDUCES),
    .TA_W            (TA_W),
    .SA_W            (SA_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid),
    .clearing     (clearing),
    .tbl_wr_en    (tbl_wr_en),
    .tbl_addr     (tbl_addr),
    .tbl_wr_data  (tbl_wr_data),
    .tbl_rd_data  (tbl_rd_data),
    .stk_wr_en    (stk_wr_en),
    .stk_wr_addr  (stk_wr_addr),
    .stk_wr_data  (stk_wr_data),
    .stk_rd_addr  (stk_rd_addr),
    .stk_rd_data  (stk_rd_data)
  );

  lrp_action_mem #(
    .DEPTH (TBL_DEPTH),
    .AW    (TA_W)
  ) u_action_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (tbl_wr_en),
    .wr_addr  (tbl_addr),
    .wr_data  (tbl_wr_data),
    .rd_addr  (tbl_addr),
    .rd_data  (tbl_rd_data),
    .clearing (clearing)
  );

  lrp_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (SA_W)
  ) u_stack_mem (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

endmodule

`default_nettype wire
